// ===== src/hbp_pkg.sv =====
// Shared constants, codes and types of the Hermite to Bezier pole streamer.
`default_nettype none

package hbp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int IN_FIELDS   = 7;
    localparam int S_TDATA_WIDTH = IN_FIELDS * COORD_WIDTH;

    localparam int KIND_WIDTH   = 2;
    localparam int MULT_WIDTH   = 3;
    localparam int STATUS_WIDTH = 2;
    localparam int M_TDATA_RAW   = 4 * COORD_WIDTH + MULT_WIDTH;
    localparam int M_TDATA_WIDTH = ((M_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TUSER_WIDTH = KIND_WIDTH + STATUS_WIDTH;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int TOL_WIDTH       = 32;

    // Shared multiplier and divide-by-three datapath.
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int QUOT_WIDTH  = PROD_WIDTH - FRAC_BITS;
    localparam int CHUNK_WIDTH = 16;
    localparam int CHUNK_COUNT = QUOT_WIDTH / CHUNK_WIDTH;
    localparam int DIVIDEND_WIDTH = CHUNK_WIDTH + 2;
    localparam int RECIP_WIDTH = 20;
    localparam int RECIP_SHIFT = 20;
    // ceil(2^20 / 3): exact quotient for any dividend below 3 * 2^16.
    localparam logic [RECIP_WIDTH-1:0] RECIP_THIRD = RECIP_WIDTH'(((1 << RECIP_SHIFT) + 2) / 3);
    localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'((3 << FRAC_BITS) / 2);
    localparam int SUM_WIDTH = QUOT_WIDTH + 2;

    localparam logic [KIND_WIDTH-1:0] KIND_POINT = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_LEAD  = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_TRAIL = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_STEP = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FEW  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OPEN = 2'd3;

    localparam logic [MULT_WIDTH-1:0] MULT_NONE  = 3'd0;
    localparam logic [MULT_WIDTH-1:0] MULT_INNER = 3'd3;
    localparam logic [MULT_WIDTH-1:0] MULT_END   = 3'd4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIODIC  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLOSE_TOL = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        coord_t                  pole_x;
        coord_t                  pole_y;
        coord_t                  pole_z;
        logic [KIND_WIDTH-1:0]   pole_kind;
        coord_t                  knot_value;
        logic [MULT_WIDTH-1:0]   knot_mult;
        logic [STATUS_WIDTH-1:0] status;
        logic                    run_end;
    } hbp_result_t;

    typedef struct packed {
        logic                   start;
        logic                   div_mode;
        logic [COORD_WIDTH-1:0] op_a;
        logic [COORD_WIDTH-1:0] op_b;
    } hbp_mul_req_t;

    typedef struct packed {
        logic                  done;
        logic [PROD_WIDTH-1:0] value;
    } hbp_mul_rsp_t;

endpackage

`default_nettype wire

// ===== src/hbp_mul_div.sv =====
// Shared multiplier with a rounding divide by (3 << FRAC_BITS), one chunk per cycle.
`default_nettype none

module hbp_mul_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hbp_pkg::hbp_mul_req_t req,
    output hbp_pkg::hbp_mul_rsp_t      rsp
);
    import hbp_pkg::*;

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MUL  = 3'd1;
    localparam logic [2:0] U_RND  = 3'd2;
    localparam logic [2:0] U_DIV  = 3'd3;
    localparam logic [2:0] U_DONE = 3'd4;
    localparam logic [1:0] LAST_CHUNK = 2'(CHUNK_COUNT - 1);

    logic [2:0]                state_reg;
    logic                      div_mode_reg;
    logic [COORD_WIDTH-1:0]    op_a_reg;
    logic [COORD_WIDTH-1:0]    op_b_reg;
    logic [PROD_WIDTH-1:0]     prod_reg;
    logic [QUOT_WIDTH-1:0]     x_reg;
    logic [QUOT_WIDTH-1:0]     quot_reg;
    logic [1:0]                rem_reg;
    logic [1:0]                chunk_reg;

    logic [DIVIDEND_WIDTH-1:0] dividend;
    logic [DIVIDEND_WIDTH+RECIP_WIDTH-1:0] recip_prod;
    logic [CHUNK_WIDTH-1:0]    digit;
    logic [DIVIDEND_WIDTH-1:0] digit_times3;
    logic [1:0]                rem_next;

    // Long division by three, sixteen bits at a time; the remainder is carried on top.
    assign dividend     = {rem_reg, x_reg[QUOT_WIDTH-1 -: CHUNK_WIDTH]};
    assign recip_prod   = (DIVIDEND_WIDTH+RECIP_WIDTH)'(dividend)
                        * (DIVIDEND_WIDTH+RECIP_WIDTH)'(RECIP_THIRD);
    assign digit        = recip_prod[RECIP_SHIFT +: CHUNK_WIDTH];
    assign digit_times3 = DIVIDEND_WIDTH'(digit) * DIVIDEND_WIDTH'(3);
    assign rem_next     = 2'(dividend - digit_times3);

    assign rsp.done  = (state_reg == U_DONE);
    assign rsp.value = div_mode_reg ? PROD_WIDTH'(quot_reg) : prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            unique case (state_reg)
                U_IDLE: begin
                    if (req.start) begin
                        state_reg <= U_MUL;
                    end
                end
                U_MUL: begin
                    state_reg <= div_mode_reg ? U_RND : U_DONE;
                end
                U_RND: begin
                    state_reg <= U_DIV;
                end
                U_DIV: begin
                    if (chunk_reg == LAST_CHUNK) begin
                        state_reg <= U_DONE;
                    end
                end
                U_DONE: begin
                    state_reg <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    div_mode_reg <= req.div_mode;
                    op_a_reg     <= req.op_a;
                    op_b_reg     <= req.op_b;
                end
            end
            U_MUL: begin
                prod_reg <= PROD_WIDTH'(op_a_reg) * PROD_WIDTH'(op_b_reg);
            end
            U_RND: begin
                x_reg     <= QUOT_WIDTH'((prod_reg + ROUND_HALF) >> FRAC_BITS);
                rem_reg   <= 2'd0;
                chunk_reg <= 2'd0;
            end
            U_DIV: begin
                quot_reg  <= {quot_reg[QUOT_WIDTH-CHUNK_WIDTH-1:0], digit};
                x_reg     <= x_reg << CHUNK_WIDTH;
                rem_reg   <= rem_next;
                chunk_reg <= chunk_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/hbp_out_reg.sv =====
// Output register of the result channel, packing a result into the stream fields.
`default_nettype none

module hbp_out_reg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               push_valid,
    input  wire hbp_pkg::hbp_result_t               push_data,
    output logic                                    push_ready,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pole_x, pole_y, pole_z, knot_value, knot_mult, zero fill
    output logic [hbp_pkg::M_TDATA_WIDTH-1:0]       m_tdata,
    // pole_kind, status
    output logic [hbp_pkg::M_TUSER_WIDTH-1:0]       m_tuser,
    output logic                                    m_tlast
);
    import hbp_pkg::*;

    logic        valid_reg;
    hbp_result_t data_reg;

    assign push_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_tdata    = M_TDATA_WIDTH'({data_reg.knot_mult, data_reg.knot_value,
                                        data_reg.pole_z, data_reg.pole_y, data_reg.pole_x});
    assign m_tuser    = {data_reg.status, data_reg.pole_kind};
    assign m_tlast    = data_reg.run_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push_valid) begin
            data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/hermite_to_bezier_poles.sv =====
// Top level: sequencer that turns Hermite fit points into Bezier poles and knots.
//
//   channel  direction  fields
//   s_       in         tdata: point xyz, slope xyz, knot_param; tlast: final_point
//   m_       out        tdata: pole xyz, knot_value, knot_mult; tuser: kind, status
//   cfg_     in         write enable, register index, write data
//
// For each later point, each of the six pole offsets passes once through the shared
// 32x32 multiplier and its three-chunk divide by three. A periodic final point adds
// the closure check on the same unit and skips the end point.
// Reset is synchronous; s_tready is high only while the sequencer is idle, and a
// stalled result channel holds the sequencer at the next result.
`default_nettype none

module hermite_to_bezier_poles (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y, point_z, slope_x, slope_y, slope_z, knot_param
    input  wire logic [hbp_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pole_x, pole_y, pole_z, knot_value, knot_mult, zero fill
    output logic [hbp_pkg::M_TDATA_WIDTH-1:0]        m_tdata,
    // pole_kind, status
    output logic [hbp_pkg::M_TUSER_WIDTH-1:0]        m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hbp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [hbp_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data
);
    import hbp_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_CL_ISSUE  = 4'd2;
    localparam logic [3:0] S_CL_WAIT   = 4'd3;
    localparam logic [3:0] S_CL_CMP    = 4'd4;
    localparam logic [3:0] S_ERR       = 4'd5;
    localparam logic [3:0] S_FIRST     = 4'd6;
    localparam logic [3:0] S_OF_ISSUE  = 4'd7;
    localparam logic [3:0] S_OF_WAIT   = 4'd8;
    localparam logic [3:0] S_PUSH_CTRL = 4'd9;
    localparam logic [3:0] S_PUSH_PT   = 4'd10;
    localparam logic [3:0] S_UPDATE    = 4'd11;
    localparam logic [1:0] LAST_AXIS   = 2'd2;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;

    logic [3:0]             state_reg;
    logic                   periodic_mode_reg;
    logic [TOL_WIDTH-1:0]   tol_reg;
    logic [1:0]             points_seen_reg;
    logic                   error_sticky_reg;

    coord_t                 p_reg [3];
    coord_t                 d_reg [3];
    coord_t                 t_reg;
    logic                   fin_reg;
    logic                   per_reg;
    logic signed [DIFF_WIDTH-1:0] step_reg;
    coord_t                 prev_point_reg [3];
    coord_t                 prev_slope_reg [3];
    coord_t                 prev_param_reg;
    coord_t                 first_point_reg [3];
    coord_t                 first_slope_reg [3];
    coord_t                 pole_reg [3];
    logic [PROD_WIDTH-1:0]  acc_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [1:0]             axis_reg;
    logic                   trail_reg;

    hbp_mul_req_t           mul_req;
    hbp_mul_rsp_t           mul_rsp;
    hbp_result_t            push_data;
    logic                   push_valid;
    logic                   push_ready;

    logic                   accept;
    logic                   wrap;
    logic                   few_points;
    logic                   bad_step;
    coord_t                 sel_slope;
    coord_t                 base;
    logic [COORD_WIDTH-1:0] slope_mag;
    logic                   eff_neg;
    logic signed [SUM_WIDTH-1:0] base_ext;
    logic signed [SUM_WIDTH-1:0] offs_ext;
    logic signed [SUM_WIDTH-1:0] pole_sum;
    coord_t                 pole_sat;
    logic signed [DIFF_WIDTH-1:0] diff;
    logic [DIFF_WIDTH-1:0]  diff_mag;
    logic                   diff_big;
    logic [PROD_WIDTH-1:0]  tol_scaled;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wrap     = per_reg && fin_reg;

    assign few_points = fin_reg && (per_reg ? (points_seen_reg < 2'd2)
                                            : (points_seen_reg == 2'd0));
    assign bad_step   = (points_seen_reg != 2'd0) && (step_reg[DIFF_WIDTH-1] || step_reg == '0);

    // Leading poles start from the previous point; trailing ones end at this point,
    // or at the stored first point when a periodic curve closes.
    always_comb begin
        if (!trail_reg) begin
            sel_slope = prev_slope_reg[axis_reg];
            base      = prev_point_reg[axis_reg];
        end else if (wrap) begin
            sel_slope = first_slope_reg[axis_reg];
            base      = first_point_reg[axis_reg];
        end else begin
            sel_slope = d_reg[axis_reg];
            base      = p_reg[axis_reg];
        end
    end

    assign slope_mag = sel_slope[COORD_WIDTH-1] ? (~sel_slope + 1'b1) : sel_slope;
    assign eff_neg   = sel_slope[COORD_WIDTH-1] ^ trail_reg;
    assign base_ext  = SUM_WIDTH'(base);
    assign offs_ext  = $signed({2'b00, mul_rsp.value[QUOT_WIDTH-1:0]});
    assign pole_sum  = eff_neg ? (base_ext - offs_ext) : (base_ext + offs_ext);

    always_comb begin
        if (pole_sum > SUM_WIDTH'(COORD_MAX)) begin
            pole_sat = COORD_MAX;
        end else if (pole_sum < SUM_WIDTH'(COORD_MIN)) begin
            pole_sat = COORD_MIN;
        end else begin
            pole_sat = COORD_WIDTH'(pole_sum);
        end
    end

    assign diff       = DIFF_WIDTH'(p_reg[axis_reg]) - DIFF_WIDTH'(first_point_reg[axis_reg]);
    assign diff_mag   = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
    assign diff_big   = |diff_mag[DIFF_WIDTH-1:COORD_WIDTH-1];
    assign tol_scaled = PROD_WIDTH'(tol_reg) << FRAC_BITS;

    always_comb begin
        mul_req.start    = (state_reg == S_OF_ISSUE) || ((state_reg == S_CL_ISSUE) && !diff_big);
        mul_req.div_mode = (state_reg == S_OF_ISSUE);
        mul_req.op_a     = (state_reg == S_OF_ISSUE) ? slope_mag : diff_mag[COORD_WIDTH-1:0];
        mul_req.op_b     = (state_reg == S_OF_ISSUE) ? step_reg[COORD_WIDTH-1:0]
                                                     : diff_mag[COORD_WIDTH-1:0];
    end

    always_comb begin
        push_valid           = 1'b0;
        push_data.pole_x     = p_reg[0];
        push_data.pole_y     = p_reg[1];
        push_data.pole_z     = p_reg[2];
        push_data.pole_kind  = KIND_POINT;
        push_data.knot_value = t_reg;
        push_data.knot_mult  = MULT_INNER;
        push_data.status     = STATUS_OK;
        push_data.run_end    = 1'b0;
        unique case (state_reg)
            S_ERR: begin
                push_valid           = 1'b1;
                push_data.pole_x     = '0;
                push_data.pole_y     = '0;
                push_data.pole_z     = '0;
                push_data.knot_value = '0;
                push_data.knot_mult  = MULT_NONE;
                push_data.status     = status_reg;
                push_data.run_end    = fin_reg;
            end
            S_FIRST: begin
                push_valid          = 1'b1;
                push_data.knot_mult = per_reg ? MULT_INNER : MULT_END;
            end
            S_PUSH_CTRL: begin
                push_valid           = 1'b1;
                push_data.pole_x     = pole_reg[0];
                push_data.pole_y     = pole_reg[1];
                push_data.pole_z     = pole_reg[2];
                push_data.pole_kind  = trail_reg ? KIND_TRAIL : KIND_LEAD;
                // On a closing span the knot rides on the trailing pole.
                push_data.knot_value = (trail_reg && wrap) ? t_reg : '0;
                push_data.knot_mult  = (trail_reg && wrap) ? MULT_INNER : MULT_NONE;
                push_data.run_end    = trail_reg && wrap;
            end
            S_PUSH_PT: begin
                push_valid          = 1'b1;
                push_data.knot_mult = (fin_reg && !per_reg) ? MULT_END : MULT_INNER;
                push_data.run_end   = fin_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            periodic_mode_reg <= 1'b0;
            tol_reg           <= '0;
            points_seen_reg   <= 2'd0;
            error_sticky_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PERIODIC:  periodic_mode_reg <= cfg_wr_data[0];
                    REG_CLOSE_TOL: tol_reg <= TOL_WIDTH'(cfg_wr_data);
                    default: begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (error_sticky_reg) begin
                        // Inputs after an error are dropped until the final point.
                        if (fin_reg) begin
                            points_seen_reg  <= 2'd0;
                            error_sticky_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end else if (few_points || bad_step) begin
                        state_reg <= S_ERR;
                    end else if (wrap) begin
                        state_reg <= S_CL_ISSUE;
                    end else if (points_seen_reg == 2'd0) begin
                        state_reg <= S_FIRST;
                    end else begin
                        state_reg <= S_OF_ISSUE;
                    end
                end
                S_CL_ISSUE: begin
                    state_reg <= diff_big ? S_ERR : S_CL_WAIT;
                end
                S_CL_WAIT: begin
                    if (mul_rsp.done) begin
                        state_reg <= (axis_reg == LAST_AXIS) ? S_CL_CMP : S_CL_ISSUE;
                    end
                end
                S_CL_CMP: begin
                    state_reg <= (acc_reg <= tol_scaled) ? S_OF_ISSUE : S_ERR;
                end
                S_ERR: begin
                    if (push_ready) begin
                        if (fin_reg) begin
                            points_seen_reg  <= 2'd0;
                            error_sticky_reg <= 1'b0;
                        end else begin
                            error_sticky_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_FIRST: begin
                    if (push_ready) begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_OF_ISSUE: begin
                    state_reg <= S_OF_WAIT;
                end
                S_OF_WAIT: begin
                    if (mul_rsp.done) begin
                        state_reg <= (axis_reg == LAST_AXIS) ? S_PUSH_CTRL : S_OF_ISSUE;
                    end
                end
                S_PUSH_CTRL: begin
                    if (push_ready) begin
                        priority if (!trail_reg) begin
                            state_reg <= S_OF_ISSUE;
                        end else if (wrap) begin
                            state_reg <= S_UPDATE;
                        end else begin
                            state_reg <= S_PUSH_PT;
                        end
                    end
                end
                S_PUSH_PT: begin
                    if (push_ready) begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (fin_reg) begin
                        points_seen_reg <= 2'd0;
                    end else if (points_seen_reg != 2'd3) begin
                        points_seen_reg <= points_seen_reg + 2'd1;
                    end
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < 3; i++) begin
                        p_reg[i] <= $signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
                        d_reg[i] <= $signed(s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH]);
                    end
                    t_reg    <= $signed(s_tdata[6*COORD_WIDTH +: COORD_WIDTH]);
                    fin_reg  <= s_tlast;
                    per_reg  <= periodic_mode_reg;
                    step_reg <= DIFF_WIDTH'($signed(s_tdata[6*COORD_WIDTH +: COORD_WIDTH]))
                              - DIFF_WIDTH'(prev_param_reg);
                end
            end
            S_CHECK: begin
                axis_reg   <= 2'd0;
                trail_reg  <= 1'b0;
                acc_reg    <= '0;
                status_reg <= few_points ? STATUS_FEW : STATUS_STEP;
            end
            S_CL_ISSUE: begin
                if (diff_big) begin
                    status_reg <= STATUS_OPEN;
                end
            end
            S_CL_WAIT: begin
                if (mul_rsp.done) begin
                    acc_reg  <= acc_reg + mul_rsp.value;
                    axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
                end
            end
            S_CL_CMP: begin
                status_reg <= STATUS_OPEN;
                axis_reg   <= 2'd0;
            end
            S_FIRST: begin
                if (push_ready) begin
                    for (int i = 0; i < 3; i++) begin
                        first_point_reg[i] <= p_reg[i];
                        first_slope_reg[i] <= d_reg[i];
                    end
                end
            end
            S_OF_WAIT: begin
                if (mul_rsp.done) begin
                    pole_reg[axis_reg] <= pole_sat;
                    axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
                end
            end
            S_PUSH_CTRL: begin
                if (push_ready) begin
                    trail_reg <= 1'b1;
                end
            end
            S_UPDATE: begin
                for (int i = 0; i < 3; i++) begin
                    prev_point_reg[i] <= p_reg[i];
                    prev_slope_reg[i] <= d_reg[i];
                end
                prev_param_reg <= t_reg;
            end
            default: begin
            end
        endcase
    end

    hbp_mul_div u_mul_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    hbp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
